// ===== rtl/vas_pkg.sv =====
// shared types, opcodes, status and class codes for the vm alu/stack execute block
// no dependencies
package vas_pkg;

  localparam int DW             = 16;
  localparam int MEM_WORDS_DEF  = 65536;
  localparam int STACK_REG_DEF  = 15;
  localparam logic [15:0] LIMIT_RST = 16'd16;

  localparam logic [3:0] OP_IO     = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_CMP    = 4'd3;
  localparam logic [3:0] OP_COPY   = 4'd4;
  localparam logic [3:0] OP_PUSH   = 4'd5;
  localparam logic [3:0] OP_POP    = 4'd6;
  localparam logic [3:0] OP_MUL    = 4'd7;
  localparam logic [3:0] OP_DIV    = 4'd8;
  localparam logic [3:0] OP_MOD    = 4'd9;
  localparam logic [3:0] OP_AND    = 4'd10;
  localparam logic [3:0] OP_OR     = 4'd11;
  localparam logic [3:0] OP_NOT    = 4'd12;
  localparam logic [3:0] OP_XOR    = 4'd13;
  localparam logic [3:0] OP_JUMP   = 4'd14;
  localparam logic [3:0] OP_PROMPT = 4'd15;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RSV   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_DIV0  = 3'd4;
  localparam logic [2:0] ST_IGN   = 3'd5;

  localparam logic [2:0] CLS_IGN  = 3'd0;
  localparam logic [2:0] CLS_PUSH = 3'd1;
  localparam logic [2:0] CLS_POP  = 3'd2;
  localparam logic [2:0] CLS_ALU  = 3'd3;
  localparam logic [2:0] CLS_DIV  = 3'd4;

  typedef struct packed {
    logic [3:0]  op;
    logic [27:0] operand_bits;
  } in_item_t;

  typedef struct packed {
    logic [15:0] write_value;
    logic        flag_zero;
    logic        flag_negative;
    logic        flag_positive;
    logic        flag_overflow;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] cls;
    in_item_t   item;
  } q_item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

// ===== rtl/vas_front.sv =====
// front end: classifies instructions and holds them in a two-entry queue
// depends on vas_pkg
module vas_front import vas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  input  back_ctl_t ctl,
  output logic      busy,
  output logic      q_valid,
  output q_item_t   q_item
);

  q_item_t    slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  logic [2:0] cls;

  always_comb begin
    if (in_data.op inside {OP_IO, OP_JUMP, OP_PROMPT}) cls = CLS_IGN;
    else if (in_data.op == OP_PUSH) cls = CLS_PUSH;
    else if (in_data.op == OP_POP) cls = CLS_POP;
    else if (in_data.op inside {OP_DIV, OP_MOD}) cls = CLS_DIV;
    else cls = CLS_ALU;
  end

  assign busy    = (cnt_r == 2'd2) || ctl.clearing;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = ctl.pop && q_valid;
  assign q_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= '{cls: cls, item: in_data};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/vas_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on vas_pkg
module vas_div import vas_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [DW:0]   shifted, trial;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign done    = done_r;
  assign quo     = quo_r;
  assign rem     = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      if (!trial[DW]) begin
        rem_r <= trial[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/vas_back.sv =====
// back end: sequencer with register file, word memory, flags and divider
// depends on vas_pkg and vas_div
module vas_back import vas_pkg::*; #(
  parameter int MEM_WORDS       = MEM_WORDS_DEF,
  parameter int STACK_REG_INDEX = STACK_REG_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] limit,
  input  logic        q_valid,
  input  q_item_t     q_item,
  output back_ctl_t   ctl,
  output logic        out_valid,
  output out_item_t   out_data
);

  localparam int IW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [63:0] RECIP = ((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
  localparam int RW = $clog2(RECIP + 64'd1);
  localparam int QW = RW - 16;
  localparam logic [3:0] SPI = 4'(STACK_REG_INDEX);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD_D  = 4'd2;
  localparam logic [3:0] S_RD_S  = 4'd3;
  localparam logic [3:0] S_RD_SP = 4'd4;
  localparam logic [3:0] S_ADDR  = 4'd5;
  localparam logic [3:0] S_QUO   = 4'd6;
  localparam logic [3:0] S_IDX   = 4'd7;
  localparam logic [3:0] S_MRD   = 4'd8;
  localparam logic [3:0] S_OPS   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_EXE   = 4'd11;
  localparam logic [3:0] S_POP2  = 4'd12;

  logic [3:0]    state_r, state_nxt;
  q_item_t       item_r;
  logic [15:0]   rf_r [16];
  logic [15:0]   mem [MEM_WORDS];
  logic [15:0]   rf_q_r, mem_q_r;
  logic [15:0]   dval_r, sval_r, spval_r;
  logic [15:0]   addr_r, addr_nxt, d_r, d_nxt, v_r, v_nxt;
  logic [QW-1:0] q_r;
  logic [IW-1:0] idx_r, clr_r;
  logic [3:0]    flags_r, flags_nxt;
  logic          out_valid_r;
  out_item_t     out_r;

  logic          emit;
  logic [15:0]   emit_wv;
  logic [2:0]    emit_st;
  logic [3:0]    rf_ra, rf_wa;
  logic          rf_we, mem_we;
  logic [15:0]   rf_wd, mem_wd;
  logic [IW-1:0] mem_wa;
  logic          div_start, div_done;
  logic [15:0]   div_quo, div_rem, div_dvs;

  logic [27:0]   b;
  logic [2:0]    mode;
  logic [3:0]    dreg;
  logic [15:0]   base, off, ofs_addr, alu_addr, res;
  logic          chk, dmem;
  logic [16:0]   sum17, diff17;
  logic signed [31:0] prod;
  logic [15+RW:0] rprod;
  logic [31:0]   qm;

  assign b    = item_r.item.operand_bits;
  assign mode = b[26:24];
  assign dreg = b[23:20];
  assign dmem = (mode == 3'd1) || (mode == 3'd2) || (mode == 3'd4) || (mode == 3'd5);
  assign chk  = (mode != 3'd0) && (mode != 3'd3);
  assign base = (mode <= 3'd5) ? dval_r : sval_r;
  assign off  = (mode == 3'd7) ? {12'd0, b[11:8]} : {12'd0, b[19:16]};
  assign ofs_addr = b[27] ? base - off : base + off;
  assign alu_addr = (mode == 3'd2 || mode == 3'd5 || mode == 3'd7) ? ofs_addr : base;

  assign sum17  = {d_r[15], d_r} + {v_r[15], v_r};
  assign diff17 = {d_r[15], d_r} - {v_r[15], v_r};
  assign prod   = $signed(d_r) * $signed(v_r);
  assign rprod  = addr_r * RW'(RECIP);
  assign qm     = 32'(q_r) * 32'(MEM_WORDS);

  assign ctl.pop      = (state_r == S_IDLE) && q_valid;
  assign ctl.clearing = (state_r == S_CLR);
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign div_dvs      = v_nxt[15] ? 16'(-v_nxt) : v_nxt;

  vas_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(d_nxt), .divisor(div_dvs),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  function automatic logic [3:0] nzp(input logic [15:0] r, input logic o);
    nzp = {r == 16'd0, r[15], !r[15] && (r != 16'd0), o};
  endfunction

  always_comb begin
    state_nxt = state_r;
    emit = 1'b0;
    emit_wv = 16'd0;
    emit_st = ST_OK;
    flags_nxt = flags_r;
    rf_ra = dreg;
    rf_we = 1'b0;
    rf_wa = dreg;
    rf_wd = 16'd0;
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = 16'd0;
    addr_nxt = addr_r;
    d_nxt = d_r;
    v_nxt = v_r;
    div_start = 1'b0;
    res = 16'd0;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        if (clr_r == IW'(MEM_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (q_valid) state_nxt = S_RD_D;
      S_RD_D: state_nxt = S_RD_S;
      S_RD_S: begin
        rf_ra = b[15:12];
        state_nxt = S_RD_SP;
      end
      S_RD_SP: begin
        rf_ra = SPI;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        state_nxt = S_QUO;
        case (item_r.cls)
          CLS_IGN: begin
            emit = 1'b1;
            emit_st = ST_IGN;
          end
          CLS_PUSH: begin
            if ({1'b0, rf_q_r} >= 17'(MEM_WORDS - 1)) begin
              emit = 1'b1;
              emit_st = ST_FULL;
            end else if (b[27:24] > 4'd1) begin
              emit = 1'b1;
            end else begin
              addr_nxt = rf_q_r + 16'd1;
            end
          end
          CLS_POP: begin
            if (rf_q_r < limit) begin
              emit = 1'b1;
              emit_st = ST_EMPTY;
            end else begin
              addr_nxt = rf_q_r;
            end
          end
          default: begin
            if (chk && alu_addr < limit) begin
              emit = 1'b1;
              emit_st = ST_RSV;
            end else begin
              addr_nxt = alu_addr;
            end
          end
        endcase
        if (emit) state_nxt = S_IDLE;
      end
      S_QUO: state_nxt = S_IDX;
      S_IDX: state_nxt = S_MRD;
      S_MRD: state_nxt = S_OPS;
      S_OPS: begin
        state_nxt = S_EXE;
        v_nxt = (mode <= 3'd2) ? b[15:0] : (mode <= 3'd5) ? sval_r : mem_q_r;
        d_nxt = dmem ? mem_q_r : dval_r;
        if (item_r.cls == CLS_DIV) begin
          if (v_nxt == 16'd0) begin
            emit = 1'b1;
            emit_st = ST_DIV0;
            state_nxt = S_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: if (div_done) state_nxt = S_EXE;
      S_EXE: begin
        emit = 1'b1;
        state_nxt = S_IDLE;
        case (item_r.cls)
          CLS_PUSH: begin
            emit_wv = (b[27:24] == 4'd0) ? sval_r : b[15:0];
            rf_we = 1'b1;
            rf_wa = SPI;
            rf_wd = addr_r;
            mem_we = 1'b1;
            mem_wd = emit_wv;
          end
          CLS_POP: begin
            emit_wv = mem_q_r;
            rf_we = (b[23:20] == 4'd0);
            rf_wa = b[19:16];
            rf_wd = mem_q_r;
            state_nxt = S_POP2;
          end
          default: begin
            case (item_r.item.op)
              OP_ADD: begin
                res = sum17[15:0];
                flags_nxt[0] = sum17[16] != sum17[15];
              end
              OP_SUB: begin
                res = diff17[15:0];
                flags_nxt[0] = diff17[16] != diff17[15];
              end
              OP_MUL: begin
                res = prod[15:0];
                flags_nxt[0] = prod[31:15] != {17{prod[15]}};
              end
              OP_DIV:  res = v_r[15] ? 16'(-div_quo) : div_quo;
              OP_MOD:  res = div_rem;
              OP_AND:  res = d_r & v_r;
              OP_OR:   res = d_r | v_r;
              OP_NOT:  res = ~v_r;
              OP_XOR:  res = d_r ^ v_r;
              default: res = v_r;
            endcase
            if (item_r.item.op == OP_CMP) begin
              if (d_r[15] && !v_r[15] && v_r != 16'd0) begin
                flags_nxt[2:1] = 2'b10;
              end else if (!d_r[15] && d_r != 16'd0 && v_r[15]) begin
                flags_nxt[2:1] = 2'b01;
              end else begin
                flags_nxt = nzp(diff17[15:0], flags_r[0]);
              end
            end else begin
              flags_nxt = nzp(res, flags_nxt[0]);
              emit_wv = res;
              if (dmem) begin
                mem_we = 1'b1;
                mem_wd = res;
              end else begin
                rf_we = 1'b1;
                rf_wd = res;
              end
            end
          end
        endcase
      end
      S_POP2: begin
        rf_we = 1'b1;
        rf_wa = SPI;
        rf_wd = (b[23:20] == 4'd0 && b[19:16] == SPI) ? mem_q_r - 16'd1 : spval_r - 16'd1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) rf_r[i] <= 16'd0;
    end else if (rf_we) begin
      rf_r[rf_wa] <= rf_wd;
    end
    rf_q_r <= rf_r[rf_ra];
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) item_r <= q_item;
    if (state_r == S_RD_S) dval_r <= rf_q_r;
    if (state_r == S_RD_SP) sval_r <= rf_q_r;
    if (state_r == S_ADDR) spval_r <= rf_q_r;
    if (state_r == S_QUO) q_r <= rprod[15+RW:32];
    if (state_r == S_IDX) idx_r <= IW'(32'(addr_r) - qm);
    addr_r <= addr_nxt;
    d_r <= d_nxt;
    v_r <= v_nxt;
    if (emit) out_r <= '{write_value: emit_wv, flag_zero: flags_nxt[3],
                         flag_negative: flags_nxt[2], flag_positive: flags_nxt[1],
                         flag_overflow: flags_nxt[0], status: emit_st};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      flags_r     <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= emit;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
    end
  end

endmodule

// ===== rtl/vm_alu_stack_execute_top.sv =====
// top level of the vm alu/stack execute block: config register, front queue, back sequencer
// depends on vas_pkg, vas_front, vas_back
// each item: register reads, address resolve, memory read, operand select, execute;
// div/mod wait on the divider; divide by zero ends at operand select, and reserved/stack
// faults and ignored opcodes end at address resolve; back sequencer holds one item at a time
// after reset the word memory is cleared one word a cycle, busy held high;
// results are strobed for one cycle; the receiver cannot stall
module vm_alu_stack_execute_top import vas_pkg::*; #(
  parameter int MEM_WORDS       = MEM_WORDS_DEF,
  parameter int STACK_REG_INDEX = STACK_REG_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic      out_valid,
  output out_item_t out_data
);

  // reserved-address limit; the user must write it only while idle, the block does not enforce this
  logic [15:0] limit_r;
  back_ctl_t   ctl;
  logic        q_valid;
  q_item_t     q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIMIT_RST;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  // front: classify and queue each transfer
  vas_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .ctl(ctl),
    .busy(busy), .q_valid(q_valid), .q_item(q_item)
  );

  // back: read registers, resolve address, access memory, execute, write back
  vas_back #(.MEM_WORDS(MEM_WORDS), .STACK_REG_INDEX(STACK_REG_INDEX)) u_back (
    .clk(clk), .rst_n(rst_n), .limit(limit_r), .q_valid(q_valid), .q_item(q_item),
    .ctl(ctl), .out_valid(out_valid), .out_data(out_data)
  );

endmodule

// ===== rtl/vas_checker.sv =====
// port-level checks on the vm alu/stack execute block, bound to the top level
// depends on vas_pkg
module vas_checker import vas_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  // results are strobed, never two in a row
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe held");

  // memory clearing holds off input right after reset
  a_clear: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_IGN)
    else $error("bad status code");

  // every non-ok status reports no written value
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.write_value == 16'd0)
    else $error("fault with write value");

endmodule

bind vm_alu_stack_execute_top vas_checker u_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid), .out_data(out_data)
);

// ===== tb/testbench.sv =====
// self-checking testbench for vm_alu_stack_execute_top: directed table then random instructions
// depends on vas_pkg and the rtl of vm_alu_stack_execute_top
`timescale 1ns / 1ps
module testbench;
  import vas_pkg::*;

  localparam int SP_REG     = STACK_REG_DEF;
  localparam int DRAIN_WAIT = 40;      // extra wait after the last expected div/mod result
  localparam int WD_LIMIT   = 200000;  // covers the memory clearing pass after reset

  typedef struct {
    in_item_t  instr;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic      out_valid;
  out_item_t out_data;

  // shadow machine state
  logic [15:0] regs_m [16];
  logic [15:0] mem_m [65536];
  bit          fz_m, fn_m, fp_m, fo_m;
  logic [15:0] limit_m = LIMIT_RST;

  out_item_t   pending_q[$];
  int          err_cnt = 0;
  int          wd_cnt = 0;
  bit          no_gap = 1'b0;

  vm_alu_stack_execute_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // instruction word builder: {op, sign, mode, dest, dest off, low 16}
  function automatic in_item_t mk(logic [3:0] op, bit sgn, bit [2:0] mode, bit [3:0] d,
                                  bit [3:0] doff, bit [15:0] low);
    in_item_t it;
    it.op = op;
    it.operand_bits = {sgn, mode, d, doff, low};
    return it;
  endfunction

  function automatic out_item_t pack_res(logic [15:0] wv, logic [2:0] st);
    out_item_t o;
    o.write_value   = wv;
    o.flag_zero     = fz_m;
    o.flag_negative = fn_m;
    o.flag_positive = fp_m;
    o.flag_overflow = fo_m;
    o.status        = st;
    return o;
  endfunction

  function automatic void set_nzp(logic [15:0] r);
    fz_m = (r == 16'h0);
    fn_m = r[15];
    fp_m = !r[15] && (r != 16'h0);
  endfunction

  // executes one instruction on the shadow state and returns the expected report
  function automatic out_item_t exec_instr(in_item_t it);
    logic [27:0] b;
    logic [15:0] sp, pv, d, r, addr, base;
    logic [3:0]  dreg, sreg;
    logic [2:0]  mode;
    bit          dmem, chk;
    int          v, sd, s;
    int unsigned av;
    b = it.operand_bits;
    r = '0;
    if (it.op == OP_IO || it.op == OP_JUMP || it.op == OP_PROMPT) return pack_res('0, ST_IGN);

    if (it.op == OP_PUSH) begin
      sp = regs_m[SP_REG];
      if (sp >= 16'hFFFF) return pack_res('0, ST_FULL);
      if (b[27:24] == 4'd0) pv = regs_m[b[15:12]];
      else if (b[27:24] == 4'd1) pv = b[15:0];
      else return pack_res('0, ST_OK);
      sp = sp + 16'd1;
      regs_m[SP_REG] = sp;
      mem_m[sp] = pv;
      return pack_res(pv, ST_OK);
    end

    if (it.op == OP_POP) begin
      sp = regs_m[SP_REG];
      if (sp < limit_m) return pack_res('0, ST_EMPTY);
      pv = mem_m[sp];
      if (b[23:20] == 4'd0) regs_m[b[19:16]] = pv;
      regs_m[SP_REG] = regs_m[SP_REG] - 16'd1;  // also when dest is the stack register
      return pack_res(pv, ST_OK);
    end

    mode = b[26:24];
    dreg = b[23:20];
    sreg = b[15:12];
    v    = int'($signed(b[15:0]));
    dmem = mode inside {3'd1, 3'd2, 3'd4, 3'd5};
    chk  = !(mode == 3'd0 || mode == 3'd3);
    base = (mode == 3'd6 || mode == 3'd7) ? regs_m[sreg] : regs_m[dreg];
    if (mode == 3'd2 || mode == 3'd5) addr = b[27] ? base - b[19:16] : base + b[19:16];
    else if (mode == 3'd7) addr = b[27] ? base - b[11:8] : base + b[11:8];
    else addr = base;
    if (mode inside {3'd3, 3'd4, 3'd5}) v = int'($signed(regs_m[sreg]));
    if (chk && addr < limit_m) return pack_res('0, ST_RSV);
    if (mode == 3'd6 || mode == 3'd7) v = int'($signed(mem_m[addr]));
    d  = dmem ? mem_m[addr] : regs_m[dreg];
    sd = int'($signed(d));

    case (it.op)
      OP_ADD: begin
        s = sd + v;
        fo_m = (s < -32768 || s > 32767);
        r = 16'(s);
      end
      OP_SUB: begin
        s = sd - v;
        fo_m = (s < -32768 || s > 32767);
        r = 16'(s);
      end
      OP_CMP: begin
        // opposite signs decide the order without the difference; zero is kept
        if (sd < 0 && v > 0) begin
          fp_m = 1'b0;
          fn_m = 1'b1;
        end else if (sd > 0 && v < 0) begin
          fp_m = 1'b1;
          fn_m = 1'b0;
        end else begin
          set_nzp(16'(sd - v));
        end
        return pack_res('0, ST_OK);
      end
      OP_COPY: r = 16'(v);
      OP_MUL: begin
        s = sd * v;
        fo_m = (s < -32768 || s > 32767);
        r = 16'(s);
      end
      OP_DIV, OP_MOD: begin
        if (v == 0) return pack_res('0, ST_DIV0);
        av = (v < 0) ? -v : v;
        if (it.op == OP_DIV) begin
          r = 16'(int'(d) / av);
          if (v < 0) r = -r;
        end else begin
          r = 16'(int'(d) % av);
        end
      end
      OP_AND: r = d & 16'(v);
      OP_OR:  r = d | 16'(v);
      OP_NOT: r = ~16'(v);
      default: r = d ^ 16'(v);
    endcase
    if (dmem) mem_m[addr] = r;
    else regs_m[dreg] = r;
    set_nzp(r);
    return pack_res(r, ST_OK);
  endfunction

  // random instruction, biased toward stack traffic and meaningful stack pointers
  function automatic in_item_t rand_instr();
    int pick;
    logic [15:0] spv;
    in_item_t it;
    pick = $urandom_range(0, 99);
    it.op = 4'($urandom_range(0, 15));
    it.operand_bits = 28'($urandom);
    if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: spv = 16'hFFFE;
        1: spv = 16'hFFFF;
        2: spv = limit_m + 16'($urandom_range(0, 3));
        default: spv = 16'($urandom);
      endcase
      it = mk(OP_COPY, 1'($urandom), 3'd0, 4'(SP_REG), 4'($urandom), spv);
    end else if (pick < 22) begin
      it.op = OP_PUSH;
      if ($urandom_range(0, 9) < 8) it.operand_bits[27:24] = 4'($urandom_range(0, 1));
    end else if (pick < 32) begin
      it.op = OP_POP;
      if ($urandom_range(0, 9) < 7) it.operand_bits[23:20] = 4'd0;
    end
    return it;
  endfunction

  // one transfer on the command side, gap drawn per item unless in a no-gap stretch
  task automatic send_instr(in_item_t it, bit typed, out_item_t typed_res);
    int gap;
    out_item_t pred;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = exec_instr(it);
    pending_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] val);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_m = val;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) no_gap = ($urandom_range(0, 3) == 0);
      send_instr(rand_instr(), 1'b0, '0);
    end
    no_gap = 1'b0;
  endtask

  // result checker: every strobed result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        want = pending_q.pop_front();
        if (out_data.write_value !== want.write_value ||
            out_data.flag_zero !== want.flag_zero ||
            out_data.flag_negative !== want.flag_negative ||
            out_data.flag_positive !== want.flag_positive ||
            out_data.flag_overflow !== want.flag_overflow ||
            out_data.status !== want.status) begin
          err_cnt++;
          if (err_cnt <= 10) $display("result mismatch: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  // watchdog: counts cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) wd_cnt <= 0;
    else wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WD_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    foreach (regs_m[i]) regs_m[i] = '0;
    foreach (mem_m[i]) mem_m[i] = '0;

    // rows with a typed result start from the reset state
    dir_tab.push_back('{mk(OP_IO, 0, 0, 0, 0, 16'h0), 1, '{16'h0, 0, 0, 0, 0, ST_IGN}});
    dir_tab.push_back('{mk(OP_ADD, 0, 0, 1, 0, 16'h7FFF), 1, '{16'h7FFF, 0, 0, 1, 0, ST_OK}});
    dir_tab.push_back('{mk(OP_ADD, 0, 0, 1, 0, 16'h0001), 1, '{16'h8000, 0, 1, 0, 1, ST_OK}});
    dir_tab.push_back('{mk(OP_DIV, 0, 0, 2, 0, 16'h0000), 1, '{16'h0, 0, 1, 0, 1, ST_DIV0}});
    dir_tab.push_back('{mk(OP_ADD, 0, 1, 0, 0, 16'h0005), 1, '{16'h0, 0, 1, 0, 1, ST_RSV}});
    dir_tab.push_back('{mk(OP_POP, 0, 0, 0, 0, 16'h0), 1, '{16'h0, 0, 1, 0, 1, ST_EMPTY}});
    // the rest goes through the predictor
    dir_tab.push_back('{mk(OP_JUMP, 1, 7, 15, 15, 16'hFFFF), 0, '0});
    dir_tab.push_back('{mk(OP_PROMPT, 0, 0, 0, 0, 16'h0), 0, '0});
    dir_tab.push_back('{mk(OP_COPY, 0, 0, 15, 0, 16'h0100), 0, '0});
    dir_tab.push_back('{mk(OP_PUSH, 0, 0, 0, 0, 16'h1000), 0, '0});      // push register
    dir_tab.push_back('{mk(OP_PUSH, 0, 1, 0, 0, 16'hFFFF), 0, '0});      // push immediate
    dir_tab.push_back('{mk(OP_PUSH, 0, 2, 0, 0, 16'h1234), 0, '0});      // mode does nothing
    dir_tab.push_back('{mk(OP_POP, 0, 0, 0, 3, 16'h0), 0, '0});
    dir_tab.push_back('{mk(OP_POP, 0, 0, 1, 3, 16'h0), 0, '0});
    dir_tab.push_back('{mk(OP_COPY, 0, 0, 4, 0, 16'h1000), 0, '0});
    dir_tab.push_back('{mk(OP_ADD, 0, 4, 4, 0, 16'h1000), 0, '0});
    dir_tab.push_back('{mk(OP_SUB, 1, 5, 4, 15, 16'h1000), 0, '0});
    dir_tab.push_back('{mk(OP_MUL, 0, 6, 5, 0, 16'h4000), 0, '0});
    dir_tab.push_back('{mk(OP_CMP, 0, 0, 1, 0, 16'h0005), 0, '0});      // negative vs positive
    dir_tab.push_back('{mk(OP_CMP, 0, 3, 4, 0, 16'h1000), 0, '0});      // positive vs negative
    dir_tab.push_back('{mk(OP_DIV, 0, 0, 1, 0, 16'hFFFD), 0, '0});      // negative divisor
    dir_tab.push_back('{mk(OP_MOD, 1, 7, 4, 0, 16'h4F00), 0, '0});
    dir_tab.push_back('{mk(OP_AND, 0, 0, 1, 0, 16'hF0F0), 0, '0});
    dir_tab.push_back('{mk(OP_OR, 0, 2, 4, 1, 16'h00FF), 0, '0});
    dir_tab.push_back('{mk(OP_NOT, 0, 0, 6, 0, 16'h1234), 0, '0});
    dir_tab.push_back('{mk(OP_XOR, 0, 3, 6, 0, 16'h1000), 0, '0});
    dir_tab.push_back('{mk(OP_MUL, 0, 0, 1, 0, 16'h7FFF), 0, '0});      // signed overflow
    dir_tab.push_back('{mk(OP_COPY, 0, 0, 15, 0, 16'hFFFF), 0, '0});
    dir_tab.push_back('{mk(OP_PUSH, 0, 1, 0, 0, 16'h0001), 0, '0});     // stack full
    dir_tab.push_back('{mk(OP_COPY, 0, 0, 15, 0, 16'h0200), 0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_instr(dir_tab[i].instr, dir_tab[i].typed, dir_tab[i].res);
    run_random(450);

    // limit phases, each written with the block drained and idle
    wait_drained();
    write_limit(16'h0000);
    run_random(400);
    wait_drained();
    write_limit(16'hFFFF);
    run_random(150);
    wait_drained();
    write_limit(16'($urandom_range(17, 16'h8000)));
    run_random(500);
    wait_drained();
    write_limit(LIMIT_RST);
    run_random(250);

    wait_drained();
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vas_pkg.sv
rtl/vas_front.sv
rtl/vas_div.sv
rtl/vas_back.sv
rtl/vm_alu_stack_execute_top.sv
rtl/vas_checker.sv
tb/testbench.sv
